[rtl/pn2_pkg.sv]
// pn2_pkg: shared constants, register indexes and helper functions of the noise block
`default_nettype none

package pn2_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ANGLE_BITS_DEF = 10;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned SIN_W     = 17;

  localparam logic [CFG_DAT_W-1:0] MAP_SIZE_RST = 16'd256;

  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned FADE_C5 = 6;
  localparam int unsigned FADE_C4 = 15;
  localparam int unsigned FADE_C3 = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 4'd0,
    CFG_MAP_HEIGHT = 4'd1
  } cfg_idx_t;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // divide a taylor term by (2n)(2n+1)
  function automatic logic [63:0] term_div(input logic [63:0] v, input int n);
    logic [63:0] res;
    unique case (n)
      1: res = v / 64'd6;
      2: res = v / 64'd20;
      3: res = v / 64'd42;
      4: res = v / 64'd72;
      5: res = v / 64'd110;
      default: res = v / 64'd156;
    endcase
    return res;
  endfunction

  // first-quadrant sine in q15 from a q30 taylor series, used to build the table
  function automatic logic [SIN_W-1:0] quarter_sine(input int unsigned r,
                                                    input int unsigned angle_bits);
    logic [63:0] x;
    logic [63:0] mag;
    logic [63:0] sum;
    logic [63:0] rnd;
    int n;
    x = (64'(r) * HALF_PI_Q30) >> (angle_bits - 2);
    mag = x;
    sum = x;
    for (n = 1; n <= 6; n++) begin
      mag = (mag * x) >> 30;
      mag = (mag * x) >> 30;
      mag = term_div(mag, n);
      if (n % 2 == 1) begin
        sum = (mag > sum) ? 64'd0 : sum - mag;
      end else begin
        sum = sum + mag;
      end
    end
    rnd = (sum + 64'd16384) >> 15;
    return rnd[SIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/pn2_div.sv]
// pn2_div: pipelined restoring divider, one quotient bit per stage
`default_nettype none

module pn2_div #(
  parameter int unsigned FRAC_BITS = pn2_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic [pn2_pkg::COORD_W-1:0]            divisor,
  input  wire logic [pn2_pkg::COORD_W-1:0]            dividend,
  output logic      [pn2_pkg::COORD_W+FRAC_BITS-1:0]  quotient
);
  import pn2_pkg::*;

  localparam int unsigned QW = COORD_W + FRAC_BITS;

  logic [COORD_W-1:0] rem_r [QW];
  logic [COORD_W-1:0] num_r [QW];
  logic [QW-1:0]      quo_r [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [COORD_W-1:0] rem_in;
      logic [COORD_W-1:0] num_in;
      logic [QW-1:0]      quo_in;
      logic [COORD_W:0]   trial;
      logic               ge;
      logic [COORD_W-1:0] rem_nxt;
      logic [COORD_W-1:0] num_nxt;
      logic [QW-1:0]      quo_nxt;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign num_in = dividend;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign num_in = num_r[k-1];
        assign quo_in = quo_r[k-1];
      end

      always_comb begin
        trial   = {rem_in, num_in[COORD_W-1]};
        ge      = (trial >= {1'b0, divisor});
        rem_nxt = ge ? COORD_W'(trial - {1'b0, divisor}) : trial[COORD_W-1:0];
        num_nxt = {num_in[COORD_W-2:0], 1'b0};
        quo_nxt = {quo_in[QW-2:0], ge};
      end

      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= num_nxt;
        quo_r[k] <= quo_nxt;
      end
    end
  endgenerate

  assign quotient = quo_r[QW-1];

endmodule

`default_nettype wire

[rtl/perlin_noise_2d.sv]
// perlin_noise_2d: pipelined 2d gradient noise, one sample per pixel coordinate pair
// throughput: one request per cycle, busy stays low; the divider takes 16 + FRAC_BITS stages
// followed by eleven stages of hashing, gradient lookup, dot products, fade and blend
// the receiver cannot stall; each result is strobed by out_valid for one cycle
// reset (synchronous, rst_n low) clears the valid pipe and sets both map sizes to 256
`default_nettype none

module perlin_noise_2d #(
  parameter int unsigned FRAC_BITS  = pn2_pkg::FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS = pn2_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pn2_pkg::COORD_W-1:0]        in_pixel_x,
  input  wire logic [pn2_pkg::COORD_W-1:0]        in_pixel_y,
  output logic                                    out_valid,
  output logic signed [15:0]                      out_noise_value,
  input  wire logic                               cfg_we,
  input  wire logic [pn2_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pn2_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import pn2_pkg::*;

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned AB      = ANGLE_BITS;
  localparam int unsigned QW      = COORD_W + F;
  localparam int unsigned LAT     = QW + 11;
  localparam int unsigned QUARTER = 1 << (AB - 2);
  localparam int unsigned AW      = AB - 1;
  localparam int unsigned FW      = F + 4;
  localparam int unsigned PW      = F + 19;
  localparam int unsigned SW      = PW + 1;
  localparam int unsigned NW      = 20;
  localparam int unsigned LW      = NW + 1 + FW + 1;
  localparam int unsigned RW      = NW + 2;
  localparam int unsigned MW      = RW + 1 + FW + 1;
  localparam int unsigned BW      = RW + 2;

  typedef logic [SIN_W-1:0] qsin_tab_t [QUARTER+1];

  function automatic qsin_tab_t qsin_build();
    qsin_tab_t tab;
    int unsigned i;
    for (i = 0; i <= QUARTER; i++) begin
      tab[i] = quarter_sine(i, AB);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = qsin_build();

  // configuration
  logic [CFG_DAT_W-1:0] map_width_r;
  logic [CFG_DAT_W-1:0] map_height_r;
  logic [CFG_DAT_W-1:0] div_w;
  logic [CFG_DAT_W-1:0] div_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_SIZE_RST;
      map_height_r <= MAP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        CFG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a zero divisor counts as one
  assign div_w = (map_width_r == '0) ? CFG_DAT_W'(1) : map_width_r;
  assign div_h = (map_height_r == '0) ? CFG_DAT_W'(1) : map_height_r;

  // valid pipe
  logic [LAT-1:0] vld_r;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  assign out_valid = vld_r[LAT-1];

  // scaling into noise space
  logic [QW-1:0] pos_x;
  logic [QW-1:0] pos_y;

  pn2_div #(.FRAC_BITS(F)) u_div_x (
    .clk      (clk),
    .divisor  (div_w),
    .dividend (in_pixel_x),
    .quotient (pos_x)
  );

  pn2_div #(.FRAC_BITS(F)) u_div_y (
    .clk      (clk),
    .divisor  (div_h),
    .dividend (in_pixel_y),
    .quotient (pos_y)
  );

  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [F-1:0]       fx;
  logic [F-1:0]       fy;

  assign cx = pos_x[QW-1:F];
  assign cy = pos_y[QW-1:F];
  assign fx = pos_x[F-1:0];
  assign fy = pos_y[F-1:0];

  // stage 1: first hash multiply, fade square
  logic [31:0]        e1_a_nxt [2];
  logic [31:0]        e1_a_r   [2];
  logic [COORD_W-1:0] e1_cy_r;
  logic [F-1:0]       e1_fx_r, e1_fy_r;
  logic [F-1:0]       e1_t2x_nxt, e1_t2y_nxt;
  logic [F-1:0]       e1_t2x_r, e1_t2y_r;

  always_comb begin
    logic [2*F-1:0] sqx;
    logic [2*F-1:0] sqy;
    for (int i = 0; i < 2; i++) begin
      e1_a_nxt[i] = (32'(cx) + 32'(i)) * HASH_MUL_A;
    end
    sqx = fx * fx;
    sqy = fy * fy;
    e1_t2x_nxt = sqx[2*F-1:F];
    e1_t2y_nxt = sqy[2*F-1:F];
  end

  always_ff @(posedge clk) begin
    e1_a_r   <= e1_a_nxt;
    e1_cy_r  <= cy;
    e1_fx_r  <= fx;
    e1_fy_r  <= fy;
    e1_t2x_r <= e1_t2x_nxt;
    e1_t2y_r <= e1_t2y_nxt;
  end

  // stage 2: second hash multiply, fade cube and polynomial
  logic [31:0]   e2_b_nxt [4];
  logic [31:0]   e2_b_r   [4];
  logic [31:0]   e2_a_r   [2];
  logic [F-1:0]  e2_fx_r, e2_fy_r;
  logic [F-1:0]  e2_t3x_nxt, e2_t3y_nxt, e2_t3x_r, e2_t3y_r;
  logic [FW-1:0] e2_px_nxt, e2_py_nxt, e2_px_r, e2_py_r;

  function automatic logic [FW-1:0] fade_poly(input logic [F-1:0] t, input logic [F-1:0] t2);
    logic [FW-1:0] pos;
    logic [FW-1:0] neg;
    pos = FW'(FADE_C5) * FW'(t2) + (FW'(FADE_C3) << F);
    neg = FW'(FADE_C4) * FW'(t);
    return (neg > pos) ? '0 : FW'(pos - neg);
  endfunction

  always_comb begin
    logic [2*F-1:0] cbx;
    logic [2*F-1:0] cby;
    for (int c = 0; c < 4; c++) begin
      e2_b_nxt[c] = ((32'(e1_cy_r) + 32'(c / 2)) ^ rot16(e1_a_r[c % 2])) * HASH_MUL_B;
    end
    cbx = e1_t2x_r * e1_fx_r;
    cby = e1_t2y_r * e1_fy_r;
    e2_t3x_nxt = cbx[2*F-1:F];
    e2_t3y_nxt = cby[2*F-1:F];
    e2_px_nxt  = fade_poly(e1_fx_r, e1_t2x_r);
    e2_py_nxt  = fade_poly(e1_fy_r, e1_t2y_r);
  end

  always_ff @(posedge clk) begin
    e2_b_r   <= e2_b_nxt;
    e2_a_r   <= e1_a_r;
    e2_fx_r  <= e1_fx_r;
    e2_fy_r  <= e1_fy_r;
    e2_t3x_r <= e2_t3x_nxt;
    e2_t3y_r <= e2_t3y_nxt;
    e2_px_r  <= e2_px_nxt;
    e2_py_r  <= e2_py_nxt;
  end

  // stage 3: final hash multiply, fade weight
  logic [31:0]   e3_h_nxt [4];
  logic [31:0]   e3_h_r   [4];
  logic [F-1:0]  e3_fx_r, e3_fy_r;
  logic [FW-1:0] e3_u_nxt, e3_v_nxt, e3_u_r, e3_v_r;

  always_comb begin
    logic [F+FW-1:0] fpx;
    logic [F+FW-1:0] fpy;
    for (int c = 0; c < 4; c++) begin
      e3_h_nxt[c] = (e2_a_r[c % 2] ^ rot16(e2_b_r[c])) * HASH_MUL_C;
    end
    fpx = e2_t3x_r * e2_px_r;
    fpy = e2_t3y_r * e2_py_r;
    e3_u_nxt = fpx[F+FW-1:F];
    e3_v_nxt = fpy[F+FW-1:F];
  end

  always_ff @(posedge clk) begin
    e3_h_r  <= e3_h_nxt;
    e3_fx_r <= e2_fx_r;
    e3_fy_r <= e2_fy_r;
    e3_u_r  <= e3_u_nxt;
    e3_v_r  <= e3_v_nxt;
  end

  // stage 4: angle to table address and sign, slot 2c is sine, 2c+1 cosine
  logic [AW-1:0] e4_addr_nxt [8];
  logic [AW-1:0] e4_addr_r   [8];
  logic [7:0]    e4_neg_nxt, e4_neg_r;
  logic [F-1:0]  e4_fx_r, e4_fy_r;
  logic [FW-1:0] e4_u_r, e4_v_r;

  always_comb begin
    logic [AB-1:0] ang;
    logic [AW-1:0] rr;
    for (int s = 0; s < 8; s++) begin
      ang = e3_h_r[s / 2][31 -: AB] + ((s % 2 == 1) ? AB'(QUARTER) : AB'(0));
      rr  = {1'b0, ang[AB-3:0]};
      e4_addr_nxt[s] = ang[AB-2] ? AW'(AW'(QUARTER) - rr) : rr;
      e4_neg_nxt[s]  = ang[AB-1];
    end
  end

  always_ff @(posedge clk) begin
    e4_addr_r <= e4_addr_nxt;
    e4_neg_r  <= e4_neg_nxt;
    e4_fx_r   <= e3_fx_r;
    e4_fy_r   <= e3_fy_r;
    e4_u_r    <= e3_u_r;
    e4_v_r    <= e3_v_r;
  end

  // stage 5: sine table read
  logic [SIN_W-1:0] e5_mag_r [8];
  logic [7:0]       e5_neg_r;
  logic [F-1:0]     e5_fx_r, e5_fy_r;
  logic [FW-1:0]    e5_u_r, e5_v_r;

  always_ff @(posedge clk) begin
    for (int s = 0; s < 8; s++) begin
      e5_mag_r[s] <= QSIN[e4_addr_r[s]];
    end
    e5_neg_r <= e4_neg_r;
    e5_fx_r  <= e4_fx_r;
    e5_fy_r  <= e4_fy_r;
    e5_u_r   <= e4_u_r;
    e5_v_r   <= e4_v_r;
  end

  // stage 6: offset times gradient
  logic signed [PW-1:0] e6_p_nxt [8];
  logic signed [PW-1:0] e6_p_r   [8];
  logic [FW-1:0]        e6_u_r, e6_v_r;

  always_comb begin
    logic signed [SIN_W:0] gm;
    logic signed [SIN_W:0] g;
    logic signed [F:0]     d;
    logic [F-1:0]          fr;
    logic                  far;
    for (int s = 0; s < 8; s++) begin
      gm  = $signed({1'b0, e5_mag_r[s]});
      g   = e5_neg_r[s] ? -gm : gm;
      fr  = (s % 2 == 0) ? e5_fx_r : e5_fy_r;
      far = (s % 2 == 0) ? ((s / 2) % 2 == 1) : ((s / 2) / 2 == 1);
      d   = $signed({far, fr});
      e6_p_nxt[s] = d * g;
    end
  end

  always_ff @(posedge clk) begin
    e6_p_r <= e6_p_nxt;
    e6_u_r <= e5_u_r;
    e6_v_r <= e5_v_r;
  end

  // stage 7: corner values
  logic signed [NW-1:0] e7_n_nxt [4];
  logic signed [NW-1:0] e7_n_r   [4];
  logic [FW-1:0]        e7_u_r, e7_v_r;

  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shf;
    for (int c = 0; c < 4; c++) begin
      sum = SW'(e6_p_r[2*c]) + SW'(e6_p_r[2*c+1]);
      shf = sum >>> (F - 1);
      e7_n_nxt[c] = NW'(shf);
    end
  end

  always_ff @(posedge clk) begin
    e7_n_r <= e7_n_nxt;
    e7_u_r <= e6_u_r;
    e7_v_r <= e6_v_r;
  end

  // stage 8: horizontal blend products
  logic signed [LW-1:0] e8_d0_nxt, e8_d1_nxt, e8_d0_r, e8_d1_r;
  logic signed [NW-1:0] e8_n00_r, e8_n01_r;
  logic [FW-1:0]        e8_v_r;

  always_comb begin
    logic signed [FW:0] uw;
    uw = $signed({1'b0, e7_u_r});
    e8_d0_nxt = ((NW+1)'(e7_n_r[1]) - (NW+1)'(e7_n_r[0])) * uw;
    e8_d1_nxt = ((NW+1)'(e7_n_r[3]) - (NW+1)'(e7_n_r[2])) * uw;
  end

  always_ff @(posedge clk) begin
    e8_d0_r  <= e8_d0_nxt;
    e8_d1_r  <= e8_d1_nxt;
    e8_n00_r <= e7_n_r[0];
    e8_n01_r <= e7_n_r[2];
    e8_v_r   <= e7_v_r;
  end

  // stage 9: row values
  logic signed [RW-1:0] e9_row0_nxt, e9_row1_nxt, e9_row0_r, e9_row1_r;
  logic [FW-1:0]        e9_v_r;

  always_comb begin
    logic signed [LW-1:0] s0;
    logic signed [LW-1:0] s1;
    s0 = e8_d0_r >>> F;
    s1 = e8_d1_r >>> F;
    e9_row0_nxt = RW'(e8_n00_r) + RW'(s0);
    e9_row1_nxt = RW'(e8_n01_r) + RW'(s1);
  end

  always_ff @(posedge clk) begin
    e9_row0_r <= e9_row0_nxt;
    e9_row1_r <= e9_row1_nxt;
    e9_v_r    <= e8_v_r;
  end

  // stage 10: vertical blend product
  logic signed [MW-1:0] e10_d_nxt, e10_d_r;
  logic signed [RW-1:0] e10_row0_r;

  assign e10_d_nxt = ((RW+1)'(e9_row1_r) - (RW+1)'(e9_row0_r)) * $signed({1'b0, e9_v_r});

  always_ff @(posedge clk) begin
    e10_d_r    <= e10_d_nxt;
    e10_row0_r <= e9_row0_r;
  end

  // stage 11: blend, round to q15, saturate
  logic signed [15:0] e11_val_nxt;
  logic signed [15:0] noise_r;

  always_comb begin
    logic signed [MW-1:0] sd;
    logic signed [BW-1:0] bl;
    logic signed [BW-1:0] rq;
    sd = e10_d_r >>> F;
    bl = BW'(e10_row0_r) + BW'(sd);
    rq = (bl + BW'(1)) >>> 1;
    priority if (rq > BW'(32767)) begin
      e11_val_nxt = 16'sh7fff;
    end else if (rq < -BW'(32768)) begin
      e11_val_nxt = -16'sh8000;
    end else begin
      e11_val_nxt = rq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    noise_r <= e11_val_nxt;
  end

  assign out_noise_value = noise_r;

  // every accepted request comes out on out_valid
  a_lat_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted request did not produce a result on time");

  // no result appears without an earlier accepted request
  a_lat_back : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without matching request");

  // scaled divisors are never zero
  a_div_nz : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (div_w != '0) && (div_h != '0))
    else $error("zero divisor reached the divider");

endmodule

`default_nettype wire
